>>> rtl/eefp_pkg.sv
// ----------------------------------------------------------------------------
// Equal Earth forward projection: shared package
// Fixed-point constants, widths and helper functions for the projection core.
// ----------------------------------------------------------------------------
package eefp_pkg;

    localparam int CW           = 34;  // signed Q30 datapath width
    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_BITS    = 31;  // root bits of cos(theta) in Q30
    localparam int QUOT_BITS    = 32;  // quotient bits of the x division
    localparam int DEN_W        = 34;
    localparam int NUM_W        = 63;
    localparam int OUT_W        = 48;
    localparam int PROD_W       = 66;

    localparam logic signed [CW-1:0] PI_F        = 34'sd1686629713;
    localparam logic signed [CW-1:0] TWO_PI_F    = 34'sd3373259426;
    localparam logic signed [31:0]   HALF_PI_Q30 = 32'sd1686629713;
    localparam logic signed [CW-1:0] Q30_ONE     = 34'sd1073741824;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [29:0]          HALF_SQRT3  = 30'd929887697;
    localparam logic signed [CW-1:0] EE_C1       = 34'sd1439097512;
    localparam logic signed [CW-1:0] EE_C2       = -34'sd87086904;
    localparam logic signed [CW-1:0] EE_C3       = 34'sd958851;
    localparam logic signed [CW-1:0] EE_C4       = 34'sd4075924;
    localparam logic signed [CW-1:0] EE_C2X3     = -34'sd261260712;
    localparam logic signed [CW-1:0] EE_C3X7     = 34'sd6711957;
    localparam logic signed [CW-1:0] EE_C4X9     = 34'sd36683316;
    localparam logic signed [31:0]   ATAN_ONE    = 32'sd843314857;
    localparam logic [49:0]          OUT_MAX     = 50'h0_7FFF_FFFF_FFFF;
    localparam logic [49:0]          OUT_MIN_MAG = 50'h0_8000_0000_0000;

    localparam logic REG_RADIUS   = 1'b0;
    localparam logic REG_MERIDIAN = 1'b1;

    // atan(2^-idx) in Q30: series summed in Q62, rounded
    function automatic logic signed [31:0] atan_q30(input int idx);
        longint acc;
        longint unsigned num, rem, quo, den;
        int k, e, b;
        acc = 0;
        atan_q30 = ATAN_ONE;
        if (idx != 0) begin
            for (k = 0; k < 32; k++) begin
                e = idx * (2 * k + 1);
                if (e <= 62) begin
                    num = 64'd1 << (62 - e);
                    den = 64'(2 * k + 1);
                    rem = 0;
                    quo = 0;
                    for (b = 63; b >= 0; b--) begin
                        rem = {rem[62:0], num[b]};
                        if (rem >= den) begin
                            rem = rem - den;
                            quo[b] = 1'b1;
                        end
                    end
                    if (k[0]) acc = acc - longint'(quo);
                    else acc = acc + longint'(quo);
                end
            end
            atan_q30 = 32'((acc + 64'sd2147483648) >>> 32);
        end
    endfunction

    // Q30 product, floored
    function automatic logic signed [CW-1:0] qmul(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
        logic signed [2*CW-1:0] p;
        p = a * b;
        qmul = p[CW+29:30];
    endfunction

    // scale by radius: round half up on magnitude, apply sign, saturate
    function automatic logic [OUT_W-1:0] round_sat(input logic [PROD_W-1:0] prod,
                                                   input logic neg);
        logic [PROD_W:0] sum;
        logic [49:0] p;
        sum = {1'b0, prod} + (PROD_W+1)'(65536);
        p = sum[PROD_W:17];
        if (neg) begin
            if (p > OUT_MIN_MAG) round_sat = OUT_MIN_MAG[OUT_W-1:0];
            else round_sat = OUT_W'(-p);
        end else begin
            if (p > OUT_MAX) round_sat = OUT_MAX[OUT_W-1:0];
            else round_sat = p[OUT_W-1:0];
        end
    endfunction

endpackage

>>> rtl/eefp_cordic.sv
// ----------------------------------------------------------------------------
// Equal Earth forward projection: pipelined CORDIC
// One micro-rotation per register stage, rotation or vectoring mode.
// ----------------------------------------------------------------------------
module eefp_cordic import eefp_pkg::*; #(
    parameter int STEPS     = CORDIC_STEPS,
    parameter int W         = CW,
    parameter int SIDE_W    = 1,
    parameter bit VECTORING = 1'b0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_vld,
    input  logic signed [W-1:0] x_i,
    input  logic signed [W-1:0] y_i,
    input  logic signed [W-1:0] z_i,
    input  logic [SIDE_W-1:0]   side_i,
    output logic                out_vld,
    output logic signed [W-1:0] y_o,
    output logic signed [W-1:0] z_o,
    output logic [SIDE_W-1:0]   side_o
);

    logic                vld_reg  [STEPS];
    logic signed [W-1:0] x_reg    [STEPS];
    logic signed [W-1:0] y_reg    [STEPS];
    logic signed [W-1:0] z_reg    [STEPS];
    logic [SIDE_W-1:0]   side_reg [STEPS];

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        localparam logic signed [W-1:0] ANG = W'(atan_q30(i));
        logic signed [W-1:0] x_prev, y_prev, z_prev;
        logic signed [W-1:0] x_next, y_next, z_next;
        logic [SIDE_W-1:0]   side_prev;
        logic                vld_prev, rot_pos;

        if (i == 0) begin : g_first
            assign x_prev    = x_i;
            assign y_prev    = y_i;
            assign z_prev    = z_i;
            assign side_prev = side_i;
            assign vld_prev  = in_vld;
        end else begin : g_rest
            assign x_prev    = x_reg[i-1];
            assign y_prev    = y_reg[i-1];
            assign z_prev    = z_reg[i-1];
            assign side_prev = side_reg[i-1];
            assign vld_prev  = vld_reg[i-1];
        end

        assign rot_pos = VECTORING ? (y_prev <= 0) : (z_prev >= 0);
        assign x_next  = rot_pos ? x_prev - (y_prev >>> i) : x_prev + (y_prev >>> i);
        assign y_next  = rot_pos ? y_prev + (x_prev >>> i) : y_prev - (x_prev >>> i);
        assign z_next  = rot_pos ? z_prev - ANG : z_prev + ANG;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vld_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[i]    <= x_next;
                y_reg[i]    <= y_next;
                z_reg[i]    <= z_next;
                side_reg[i] <= side_prev;
            end
        end
    end

    assign out_vld = vld_reg[STEPS-1];
    assign y_o     = y_reg[STEPS-1];
    assign z_o     = z_reg[STEPS-1];
    assign side_o  = side_reg[STEPS-1];

endmodule

>>> rtl/eefp_isqrt.sv
// ----------------------------------------------------------------------------
// Equal Earth forward projection: pipelined integer square root
// One root bit per register stage, floor result.
// ----------------------------------------------------------------------------
module eefp_isqrt import eefp_pkg::*; #(
    parameter int NB     = SQRT_BITS,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_vld,
    input  logic [2*NB-2:0]   v_i,
    input  logic [SIDE_W-1:0] side_i,
    output logic              out_vld,
    output logic [NB-1:0]     root_o,
    output logic [SIDE_W-1:0] side_o
);

    localparam int RW = 2 * NB;

    logic              vld_reg  [NB];
    logic [RW-1:0]     rem_reg  [NB];
    logic [NB-1:0]     root_reg [NB];
    logic [SIDE_W-1:0] side_reg [NB];

    for (genvar j = 0; j < NB; j++) begin : g_bit
        localparam int B = NB - 1 - j;
        logic [RW-1:0]     rem_prev, trial, rem_next;
        logic [NB-1:0]     root_prev, root_next;
        logic [SIDE_W-1:0] side_prev;
        logic              vld_prev, take;

        if (j == 0) begin : g_first
            assign rem_prev  = {1'b0, v_i};
            assign root_prev = '0;
            assign side_prev = side_i;
            assign vld_prev  = in_vld;
        end else begin : g_rest
            assign rem_prev  = rem_reg[j-1];
            assign root_prev = root_reg[j-1];
            assign side_prev = side_reg[j-1];
            assign vld_prev  = vld_reg[j-1];
        end

        assign trial     = ({{(RW-NB){1'b0}}, root_prev} << (B + 1)) + (RW'(1) << (2 * B));
        assign take      = trial <= rem_prev;
        assign rem_next  = take ? rem_prev - trial : rem_prev;
        assign root_next = take ? root_prev | (NB'(1) << B) : root_prev;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (en) begin
                vld_reg[j] <= vld_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
                side_reg[j] <= side_prev;
            end
        end
    end

    assign out_vld = vld_reg[NB-1];
    assign root_o  = root_reg[NB-1];
    assign side_o  = side_reg[NB-1];

endmodule

>>> rtl/eefp_poly.sv
// ----------------------------------------------------------------------------
// Equal Earth forward projection: polynomial pipeline
// Powers of theta, the y polynomial times theta and the x denominator.
// ----------------------------------------------------------------------------
module eefp_poly import eefp_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_vld,
    input  logic signed [CW-1:0] th_i,
    input  logic [SIDE_W-1:0]    side_i,
    output logic                 out_vld,
    output logic signed [CW-1:0] yu_o,
    output logic [DEN_W-1:0]     den_o,
    output logic [SIDE_W-1:0]    side_o
);

    localparam int NS = 7;

    logic [NS-1:0]        vld_reg;
    logic [SIDE_W-1:0]    side_reg [NS];
    logic signed [CW-1:0] th_reg   [NS-1];
    logic signed [CW-1:0] t2_reg   [3];
    logic signed [CW-1:0] t4_reg, t6_reg, t6d_reg, t8_reg;
    logic signed [CW-1:0] a2_reg [4];
    logic signed [CW-1:0] b2_reg [4];
    logic signed [CW-1:0] a6_reg, b6_reg, a8_reg, b8_reg;
    logic signed [CW-1:0] py_reg, yu_reg;
    logic [DEN_W-1:0]     den_reg [2];
    logic signed [CW+1:0] sum_b;
    logic signed [CW+3:0] den_next;

    assign sum_b    = (CW+2)'(EE_C1) + (CW+2)'(b2_reg[3]) + (CW+2)'(b6_reg) + (CW+2)'(b8_reg);
    assign den_next = ((CW+4)'(sum_b) <<< 1) + (CW+4)'(sum_b);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NS-2:0], in_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_i;
            for (int k = 1; k < NS; k++) side_reg[k] <= side_reg[k-1];
            th_reg[0] <= th_i;
            for (int k = 1; k < NS-1; k++) th_reg[k] <= th_reg[k-1];

            t2_reg[0] <= qmul(th_i, th_i);
            t2_reg[1] <= t2_reg[0];
            t2_reg[2] <= t2_reg[1];
            t4_reg    <= qmul(t2_reg[0], t2_reg[0]);
            a2_reg[0] <= qmul(EE_C2, t2_reg[0]);
            b2_reg[0] <= qmul(EE_C2X3, t2_reg[0]);
            a2_reg[1] <= a2_reg[0];
            b2_reg[1] <= b2_reg[0];
            a2_reg[2] <= a2_reg[1];
            b2_reg[2] <= b2_reg[1];
            a2_reg[3] <= a2_reg[2];
            b2_reg[3] <= b2_reg[2];

            t6_reg  <= qmul(t4_reg, t2_reg[1]);
            t6d_reg <= t6_reg;
            t8_reg  <= qmul(t6_reg, t2_reg[2]);
            a6_reg  <= qmul(EE_C3, t6d_reg);
            b6_reg  <= qmul(EE_C3X7, t6d_reg);
            a8_reg  <= qmul(EE_C4, t8_reg);
            b8_reg  <= qmul(EE_C4X9, t8_reg);

            py_reg <= EE_C1 + a2_reg[3] + a6_reg + a8_reg;
            if (den_next < 1) den_reg[0] <= DEN_W'(1);
            else den_reg[0] <= den_next[DEN_W-1:0];

            yu_reg     <= qmul(th_reg[NS-2], py_reg);
            den_reg[1] <= den_reg[0];
        end
    end

    assign out_vld = vld_reg[NS-1];
    assign yu_o    = yu_reg;
    assign den_o   = den_reg[1];
    assign side_o  = side_reg[NS-1];

endmodule

>>> rtl/eefp_divu.sv
// ----------------------------------------------------------------------------
// Equal Earth forward projection: pipelined unsigned divider
// Restoring division, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module eefp_divu import eefp_pkg::*; #(
    parameter int DW     = NUM_W,
    parameter int VW     = DEN_W,
    parameter int QW     = QUOT_BITS,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_vld,
    input  logic [DW-1:0]     num_i,
    input  logic [VW-1:0]     den_i,
    input  logic [SIDE_W-1:0] side_i,
    output logic              out_vld,
    output logic [QW-1:0]     quot_o,
    output logic [SIDE_W-1:0] side_o
);

    logic              vld_reg  [QW];
    logic [VW-1:0]     rem_reg  [QW];
    logic [VW-1:0]     den_reg  [QW];
    logic [QW-1:0]     lo_reg   [QW];
    logic [QW-1:0]     q_reg    [QW];
    logic [SIDE_W-1:0] side_reg [QW];

    for (genvar j = 0; j < QW; j++) begin : g_bit
        logic [VW-1:0]     rem_prev, den_prev, rem_next;
        logic [QW-1:0]     lo_prev, q_prev;
        logic [SIDE_W-1:0] side_prev;
        logic [VW:0]       part;
        logic              vld_prev, take;

        if (j == 0) begin : g_first
            assign rem_prev  = VW'(num_i[DW-1:QW]);
            assign den_prev  = den_i;
            assign lo_prev   = num_i[QW-1:0];
            assign q_prev    = '0;
            assign side_prev = side_i;
            assign vld_prev  = in_vld;
        end else begin : g_rest
            assign rem_prev  = rem_reg[j-1];
            assign den_prev  = den_reg[j-1];
            assign lo_prev   = lo_reg[j-1];
            assign q_prev    = q_reg[j-1];
            assign side_prev = side_reg[j-1];
            assign vld_prev  = vld_reg[j-1];
        end

        assign part     = {rem_prev, lo_prev[QW-1]};
        assign take     = part >= {1'b0, den_prev};
        assign rem_next = take ? VW'(part - {1'b0, den_prev}) : VW'(part);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (en) begin
                vld_reg[j] <= vld_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]  <= rem_next;
                den_reg[j]  <= den_prev;
                lo_reg[j]   <= lo_prev << 1;
                q_reg[j]    <= {q_prev[QW-2:0], take};
                side_reg[j] <= side_prev;
            end
        end
    end

    assign out_vld = vld_reg[QW-1];
    assign quot_o  = q_reg[QW-1];
    assign side_o  = side_reg[QW-1];

endmodule

>>> rtl/equal_earth_forward_projection_core.sv
// Takes one longitude/latitude word per clock and returns one projected word per
// clock while the pipeline flows, through its register stages: input stage 1, sine CORDIC 30,
// scaling and squaring 3, square root 31, x numerator 2, arctangent CORDIC 30,
// polynomial 7, divider 32, radius scaling and saturation 2. The pipeline holds
// as a whole only while the output word waits and is not taken. Radius and
// central meridian are read live, so write them only while the core is empty.
// ----------------------------------------------------------------------------
// Equal Earth forward projection core
// Streaming top level: wrap, CORDIC sine, root, CORDIC arctangent, polynomial,
// division and radius scaling.
// ----------------------------------------------------------------------------
module equal_earth_forward_projection_core import eefp_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic         cfg_addr,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // lon_angle[31:0], lat_angle[62:32], zero
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata    // map_x[47:0], map_y[95:48], ok[96], zero
);

    logic [31:0] radius_reg;
    logic [31:0] meridian_reg;
    logic        en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg   <= 32'd65536;
            meridian_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_RADIUS:   radius_reg   <= cfg_wdata;
                REG_MERIDIAN: meridian_reg <= cfg_wdata;
            endcase
        end
    end

    assign en       = m_tready || !m_tvalid;
    assign s_tready = en;

    // input stage
    logic signed [31:0] lon, ph_raw;
    logic signed [30:0] lat;
    logic               a_vld_reg;
    logic signed [32:0] a_diff_reg;
    logic signed [31:0] a_ph_reg, a_ph_next;
    logic signed [CW-1:0] diff, lam_a;

    assign lon    = s_tdata[31:0];
    assign lat    = s_tdata[62:32];
    assign ph_raw = {lat, 1'b0};
    always_comb begin
        if (ph_raw > HALF_PI_Q30) a_ph_next = HALF_PI_Q30;
        else if (ph_raw < -HALF_PI_Q30) a_ph_next = -HALF_PI_Q30;
        else a_ph_next = ph_raw;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) a_vld_reg <= 1'b0;
        else if (en) a_vld_reg <= s_tvalid;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            a_diff_reg <= {lon[31], lon} - {meridian_reg[31], meridian_reg};
            a_ph_reg   <= a_ph_next;
        end
    end

    assign diff = CW'(a_diff_reg);
    always_comb begin
        if (diff > PI_F) lam_a = (diff - TWO_PI_F) <<< 1;
        else if (diff <= -PI_F) lam_a = (diff + TWO_PI_F) <<< 1;
        else lam_a = diff <<< 1;
    end

    // sine of latitude
    logic                 sin_vld;
    logic signed [CW-1:0] sin_y;
    logic [CW-1:0]        sin_lam;

    eefp_cordic #(.STEPS(CORDIC_STEPS), .W(CW), .SIDE_W(CW), .VECTORING(1'b0)) u_sin (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_vld(a_vld_reg), .x_i(CORDIC_GAIN), .y_i('0), .z_i(CW'(a_ph_reg)),
        .side_i(lam_a), .out_vld(sin_vld), .y_o(sin_y), .z_o(), .side_o(sin_lam)
    );

    // s = sqrt(3)/2 * sin, clamp, square
    logic                   b_vld_reg, c_vld_reg, d_vld_reg;
    logic signed [CW+30:0]  b_prod_reg;
    logic [CW-1:0]          b_lam_reg, c_lam_reg, d_lam_reg;
    logic signed [CW+30:0]  s_full;
    logic signed [31:0]     c_s_reg, d_s_reg, s_next;
    logic [63:0]            sq_full;
    logic [60:0]            d_sq_reg;

    assign s_full = b_prod_reg >>> 30;
    always_comb begin
        if (s_full > Q30_ONE) s_next = 32'(Q30_ONE);
        else if (s_full < -Q30_ONE) s_next = 32'(-Q30_ONE);
        else s_next = s_full[31:0];
    end
    assign sq_full = c_s_reg * c_s_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end else if (en) begin
            b_vld_reg <= sin_vld;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            b_prod_reg <= sin_y * $signed({1'b0, HALF_SQRT3});
            b_lam_reg  <= sin_lam;
            c_s_reg    <= s_next;
            c_lam_reg  <= b_lam_reg;
            d_sq_reg   <= sq_full[60:0];
            d_s_reg    <= c_s_reg;
            d_lam_reg  <= c_lam_reg;
        end
    end

    // cos(theta) = sqrt(1 - s^2)
    logic                 rt_vld;
    logic [SQRT_BITS-1:0] rt_c;
    logic [CW+31:0]       rt_side;

    eefp_isqrt #(.NB(SQRT_BITS), .SIDE_W(CW + 32)) u_root (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_vld(d_vld_reg), .v_i(61'h1000_0000_0000_0000 - d_sq_reg),
        .side_i({d_s_reg, d_lam_reg}),
        .out_vld(rt_vld), .root_o(rt_c), .side_o(rt_side)
    );

    // x numerator
    logic                  e_vld_reg, f_vld_reg;
    logic signed [CW+31:0] u_prod;
    logic signed [CW-1:0]  e_u_reg, u_mag;
    logic [SQRT_BITS-1:0]  e_c_reg, f_c_reg;
    logic signed [31:0]    e_s_reg, f_s_reg;
    logic [NUM_W-1:0]      f_w_reg;
    logic                  f_neg_reg;

    assign u_prod = $signed(rt_side[CW-1:0]) * $signed({1'b0, rt_c});
    assign u_mag  = e_u_reg[CW-1] ? -e_u_reg : e_u_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
        end else if (en) begin
            e_vld_reg <= rt_vld;
            f_vld_reg <= e_vld_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            e_u_reg   <= u_prod[CW+29:30];
            e_c_reg   <= rt_c;
            e_s_reg   <= rt_side[CW+31:CW];
            f_w_reg   <= u_mag[CW-2:0] * HALF_SQRT3;
            f_neg_reg <= e_u_reg[CW-1];
            f_c_reg   <= e_c_reg;
            f_s_reg   <= e_s_reg;
        end
    end

    // theta = atan2(s, cos)
    logic                 at_vld;
    logic signed [CW-1:0] at_th;
    logic [NUM_W:0]       at_side;

    eefp_cordic #(.STEPS(CORDIC_STEPS), .W(CW), .SIDE_W(NUM_W + 1), .VECTORING(1'b1)) u_atan (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_vld(f_vld_reg), .x_i(CW'({1'b0, f_c_reg})), .y_i(CW'(f_s_reg)), .z_i('0),
        .side_i({f_neg_reg, f_w_reg}), .out_vld(at_vld), .y_o(), .z_o(at_th),
        .side_o(at_side)
    );

    // polynomials
    logic                 pl_vld;
    logic signed [CW-1:0] pl_yu;
    logic [DEN_W-1:0]     pl_den;
    logic [NUM_W:0]       pl_side;

    eefp_poly #(.SIDE_W(NUM_W + 1)) u_poly (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_vld(at_vld), .th_i(at_th), .side_i(at_side),
        .out_vld(pl_vld), .yu_o(pl_yu), .den_o(pl_den), .side_o(pl_side)
    );

    // x quotient
    logic                 dv_vld;
    logic [QUOT_BITS-1:0] dv_q;
    logic [CW:0]          dv_side;

    eefp_divu #(.DW(NUM_W), .VW(DEN_W), .QW(QUOT_BITS), .SIDE_W(CW + 1)) u_div (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_vld(pl_vld), .num_i(pl_side[NUM_W-1:0]), .den_i(pl_den),
        .side_i({pl_side[NUM_W], pl_yu}),
        .out_vld(dv_vld), .quot_o(dv_q), .side_o(dv_side)
    );

    // radius scaling and saturation
    logic                 g_vld_reg, h_vld_reg;
    logic [PROD_W-1:0]    g_px_reg, g_py_reg;
    logic                 g_xneg_reg, g_yneg_reg, g_ok_reg, h_ok_reg;
    logic signed [CW-1:0] dv_yu, y_mag;
    logic [OUT_W-1:0]     h_x_reg, h_y_reg;

    assign dv_yu = dv_side[CW-1:0];
    assign y_mag = dv_yu[CW-1] ? -dv_yu : dv_yu;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_vld_reg <= 1'b0;
            h_vld_reg <= 1'b0;
        end else if (en) begin
            g_vld_reg <= dv_vld;
            h_vld_reg <= g_vld_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            g_px_reg   <= radius_reg * {dv_q, 2'b00};
            g_py_reg   <= radius_reg * y_mag;
            g_xneg_reg <= dv_side[CW];
            g_yneg_reg <= dv_yu[CW-1];
            g_ok_reg   <= radius_reg != '0;
            h_x_reg    <= round_sat(g_px_reg, g_xneg_reg);
            h_y_reg    <= round_sat(g_py_reg, g_yneg_reg);
            h_ok_reg   <= g_ok_reg;
        end
    end

    assign m_tvalid = h_vld_reg;
    assign m_tdata  = {7'b0, h_ok_reg, h_y_reg, h_x_reg};

endmodule

>>> rtl/eefp_checker.sv
// ----------------------------------------------------------------------------
// Equal Earth forward projection: port checker
// Watches the stream ports of the core over time; bound to the top level.
// ----------------------------------------------------------------------------
module eefp_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata
);

    // a held output word stays put
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while held");

    // input side flows whenever the output side does
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tready || !m_tvalid) |-> s_tready)
        else $error("input stalled with free output");

    // reset leaves no valid output word
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output word valid after reset");

    // a rejected word carries zero coordinates
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[96] |-> m_tdata[95:0] == 96'd0)
        else $error("rejected word with non-zero coordinates");

endmodule

bind equal_earth_forward_projection_core eefp_checker u_eefp_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
);
